/* rtl/core/pts_pkg.sv */
// Shared types and codes for the priority task scheduler.
`default_nettype none
package pts_pkg;

	localparam int PRIO_W = 5;
	localparam int TIME_W = 32;
	localparam int SLOT_W = 3;

	typedef enum logic [1:0] {
		OP_CREATE   = 2'd0,
		OP_TICK     = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_COMPLETE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REJECT   = 2'd1,
		ST_NO_READY = 2'd2,
		ST_NOT_RUN  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MODE_SLEEP = 2'd0,
		MODE_READY = 2'd1,
		MODE_RUN   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_INSERT,
		S_WAKE,
		S_RESP
	} state_t;

	typedef struct packed {
		logic in_rdy;
		logic exec;
		logic insert;
		logic wake;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic go_insert;
		logic go_wake;
		logic wake_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/core/pts_in_if.sv */
// Input and output channel interfaces of the scheduler.
`default_nettype none
interface pts_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [4:0]  priority_req;
	logic [31:0] period;
	logic [31:0] delta;
	logic [2:0]  slot;

	modport source (output valid, op, priority_req, period, delta, slot, input ready);
	modport sink (input valid, op, priority_req, period, delta, slot, output ready);
endinterface

interface pts_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  task_slot;
	logic [31:0] now;

	modport source (output valid, status, task_slot, now, input ready);
	modport sink (input valid, status, task_slot, now, output ready);
endinterface
`default_nettype wire

/* rtl/core/priority_task_scheduler.sv */
// Dispatch and rejected ops go from execute to the result; create/complete add the
// queue insert step, and tick runs the wake loop, which wakes due tasks one at a time.
// A new word is taken only after the result is registered and the controller is idle;
// ops do not overlap, as they share the single slot-table update path stepped by the
// controller. A stalled result holds the input off.
// arst_n clears time, the used mask, slot modes and ranks; slot data stays undefined
// until a create writes it.
`default_nettype none
module priority_task_scheduler
	import pts_pkg::*;
#(
	parameter int NUM_SLOTS   = 8,
	parameter int PRIO_LEVELS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pts_in_if.sink    in_ch,
	pts_out_if.source out_ch
);

	cmd_t cmd;
	sts_t sts;

	pts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	pts_dpath #(
		.NUM_SLOTS   (NUM_SLOTS),
		.PRIO_LEVELS (PRIO_LEVELS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
`default_nettype wire

/* rtl/core/pts_dpath.sv */
// Scheduler datapath: slot table, time, ready and sleep ordering, result register.
`default_nettype none
module pts_dpath
	import pts_pkg::*;
#(
	parameter int NUM_SLOTS   = 8,
	parameter int PRIO_LEVELS = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pts_in_if.sink      in_ch,
	pts_out_if.source   out_ch,
	input  cmd_t        cmd,
	output sts_t        sts
);

	localparam int RW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// captured word
	op_t                 op_q;
	logic [PRIO_W-1:0]   prio_in_q;
	logic [TIME_W-1:0]   period_in_q;
	logic [TIME_W-1:0]   delta_q;
	logic [SLOT_W-1:0]   slot_in_q;

	// slot table
	logic [NUM_SLOTS-1:0] used_q;
	mode_t               mode_q   [NUM_SLOTS];
	logic [RW-1:0]       rank_q   [NUM_SLOTS];
	logic [PRIO_W-1:0]   prio_q   [NUM_SLOTS];
	logic [TIME_W-1:0]   period_q [NUM_SLOTS];
	logic [TIME_W-1:0]   due_q    [NUM_SLOTS];
	logic [TIME_W-1:0]   now_q;
	logic [NUM_SLOTS-1:0] tgt_q;

	status_t             res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [TIME_W-1:0]   out_now_q;

	logic [NUM_SLOTS-1:0] sleeping, ready_m, run_m;
	logic [NUM_SLOTS-1:0] free_first, slot_sel, best, head, le_mask;
	logic [RW-1:0]       rank_best, pos;
	logic [TIME_W-1:0]   period_sel, due_tgt, due_head, diff;
	logic                create_ok, disp_ok, cpl_ok, wake_done;

	function automatic logic [SLOT_W-1:0] enc(input logic [NUM_SLOTS-1:0] oh);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (oh[i]) r = SLOT_W'(i);
		return r;
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			sleeping[i] = used_q[i] && mode_q[i] == MODE_SLEEP;
			ready_m[i]  = used_q[i] && mode_q[i] == MODE_READY;
			run_m[i]    = used_q[i] && mode_q[i] == MODE_RUN;
			slot_sel[i] = int'(slot_in_q) == i;
			head[i]     = sleeping[i] && rank_q[i] == '0;
		end
	end

	// lowest clear bit of the used mask
	assign free_first = ~used_q & (used_q + NUM_SLOTS'(1));

	// most urgent ready slot: highest priority, then lowest rank, one key bit at a time
	always_comb begin
		logic [NUM_SLOTS-1:0] bitv;
		best = ready_m;
		for (int b = PRIO_W - 1; b >= 0; b--) begin
			for (int i = 0; i < NUM_SLOTS; i++) bitv[i] = prio_q[i][b];
			if (|(best & bitv)) best = best & bitv;
		end
		for (int b = RW - 1; b >= 0; b--) begin
			for (int i = 0; i < NUM_SLOTS; i++) bitv[i] = ~rank_q[i][b];
			if (|(best & bitv)) best = best & bitv;
		end
	end

	always_comb begin
		rank_best  = '0;
		period_sel = '0;
		due_tgt    = '0;
		due_head   = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (best[i])     rank_best  = rank_best | rank_q[i];
			if (slot_sel[i]) period_sel = period_sel | period_q[i];
			if (tgt_q[i])    due_tgt    = due_tgt | due_q[i];
			if (head[i])     due_head   = due_head | due_q[i];
		end
	end

	// queue position of the slot being put to sleep
	always_comb begin
		logic [RW:0] sum;
		sum = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			le_mask[i] = sleeping[i] && !tgt_q[i] && (due_q[i] <= due_tgt);
			sum = sum + {{RW{1'b0}}, le_mask[i]};
		end
		pos = sum[RW-1:0];
	end

	assign diff      = due_head - now_q;
	assign wake_done = !(|head) || (diff != '0 && !diff[TIME_W-1]);

	assign create_ok = (|free_first) && int'(prio_in_q) < PRIO_LEVELS;
	assign disp_ok   = |ready_m;
	assign cpl_ok    = |(slot_sel & run_m);

	assign in_ch.ready   = cmd.in_rdy;
	assign sts.in_valid  = in_ch.valid;
	assign sts.go_insert = (op_q == OP_CREATE && create_ok) || (op_q == OP_COMPLETE && cpl_ok);
	assign sts.go_wake   = op_q == OP_TICK;
	assign sts.wake_done = wake_done;
	assign sts.out_free  = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			now_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				mode_q[i] <= MODE_SLEEP;
				rank_q[i] <= '0;
			end
		end else begin
			if (cmd.exec) begin
				unique case (op_q)
					OP_CREATE: begin
						if (create_ok) used_q <= used_q | free_first;
					end
					OP_TICK: now_q <= now_q + delta_q;
					OP_DISPATCH: begin
						if (disp_ok) begin
							for (int i = 0; i < NUM_SLOTS; i++) begin
								if (best[i]) begin
									mode_q[i] <= MODE_RUN;
									rank_q[i] <= '0;
								end else if (ready_m[i] && rank_q[i] > rank_best) begin
									rank_q[i] <= rank_q[i] - RW'(1);
								end
							end
						end
					end
					OP_COMPLETE: ;
					default: ;
				endcase
			end
			if (cmd.insert) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (tgt_q[i]) begin
						mode_q[i] <= MODE_SLEEP;
						rank_q[i] <= pos;
					end else if (sleeping[i] && !le_mask[i]) begin
						rank_q[i] <= rank_q[i] + RW'(1);
					end
				end
			end
			if (cmd.wake && !wake_done) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (head[i]) begin
						mode_q[i] <= MODE_READY;
						rank_q[i] <= '0;
					end else if (ready_m[i]) begin
						rank_q[i] <= rank_q[i] + RW'(1);
					end else if (sleeping[i]) begin
						rank_q[i] <= rank_q[i] - RW'(1);
					end
				end
			end
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_rdy && in_ch.valid) begin
			op_q        <= op_t'(in_ch.op);
			prio_in_q   <= in_ch.priority_req;
			period_in_q <= in_ch.period;
			delta_q     <= in_ch.delta;
			slot_in_q   <= in_ch.slot;
		end
		if (cmd.exec) begin
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			unique case (op_q)
				OP_CREATE: begin
					if (create_ok) begin
						for (int i = 0; i < NUM_SLOTS; i++) begin
							if (free_first[i]) begin
								prio_q[i]   <= prio_in_q;
								period_q[i] <= period_in_q;
								due_q[i]    <= now_q + period_in_q;
							end
						end
						tgt_q      <= free_first;
						res_slot_q <= enc(free_first);
					end else begin
						res_status_q <= ST_REJECT;
					end
				end
				OP_TICK: ;
				OP_DISPATCH: begin
					if (disp_ok) res_slot_q <= enc(best);
					else res_status_q <= ST_NO_READY;
				end
				OP_COMPLETE: begin
					if (cpl_ok) begin
						for (int i = 0; i < NUM_SLOTS; i++)
							if (slot_sel[i]) due_q[i] <= now_q + period_sel;
						tgt_q <= slot_sel;
					end else begin
						res_status_q <= ST_NOT_RUN;
					end
				end
				default: ;
			endcase
		end
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_now_q    <= now_q;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.status    = out_status_q;
	assign out_ch.task_slot = out_slot_q;
	assign out_ch.now       = out_now_q;

endmodule
`default_nettype wire

/* rtl/core/pts_ctrl.sv */
// Scheduler controller: sequences accept, execute, queue insert, wake loop and result.
`default_nettype none
module pts_ctrl
	import pts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  sts_t      sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (sts.in_valid) state_d = S_EXEC;
			S_EXEC: begin
				priority if (sts.go_insert) state_d = S_INSERT;
				else if (sts.go_wake)       state_d = S_WAKE;
				else                        state_d = S_RESP;
			end
			S_INSERT: state_d = S_RESP;
			S_WAKE:   if (sts.wake_done) state_d = S_RESP;
			S_RESP:   if (sts.out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.in_rdy = state_q == S_IDLE;
		cmd.exec   = state_q == S_EXEC;
		cmd.insert = state_q == S_INSERT;
		cmd.wake   = state_q == S_WAKE;
		cmd.load   = state_q == S_RESP && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire
